/* sv/mvm_pkg.sv */
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int ACC_W      = 40;
  localparam int ROW_W      = 16;
  localparam int COLS_REG_W = 9;
  localparam int ROWS_REG_W = 16;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd256;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 16'd1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b1;

  localparam logic KIND_VECTOR = 1'b0;
  localparam logic KIND_MATRIX = 1'b1;

  // row bookkeeping that rides along with one matrix element
  typedef struct packed {
    logic             last_col;
    logic [ROW_W-1:0] row_number;
    logic             last_row;
  } tag_t;

endpackage

/* sv/mvm_ram.sv */
`timescale 1ns / 1ps

module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mvm_seq.sv */
`timescale 1ns / 1ps

module mvm_seq #(
  parameter int MAX_COLS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  logic [mvm_pkg::COLS_REG_W-1:0]       num_cols,
  input  logic [mvm_pkg::ROWS_REG_W-1:0]       num_rows,
  output logic [$clog2(MAX_COLS)-1:0]          col,
  output mvm_pkg::tag_t                        tag
);

  localparam int AddrW = $clog2(MAX_COLS);
  localparam int BaseW = (AddrW + 1 > mvm_pkg::COLS_REG_W) ? AddrW + 1 : mvm_pkg::COLS_REG_W;
  localparam int CmpW  = BaseW + 1;
  localparam int RowW  = mvm_pkg::ROW_W;

  logic [AddrW-1:0] col_r, col_nxt;
  logic [RowW-1:0]  row_r, row_nxt;

  logic [CmpW-1:0]  cols_eff;
  logic [CmpW-1:0]  col_plus;
  logic [RowW:0]    rows_eff;
  logic [RowW:0]    row_plus;
  logic             last_col;
  logic             last_row;

  always_comb begin
    // zero acts as one, anything past the store acts as the store size
    if (num_cols == '0) begin
      cols_eff = CmpW'(1);
    end else if (CmpW'(num_cols) > CmpW'(MAX_COLS)) begin
      cols_eff = CmpW'(MAX_COLS);
    end else begin
      cols_eff = CmpW'(num_cols);
    end
    rows_eff = (num_rows == '0) ? (RowW + 1)'(1) : {1'b0, num_rows};
    col_plus = CmpW'(col_r) + CmpW'(1);
    row_plus = {1'b0, row_r} + (RowW + 1)'(1);
    last_col = (col_plus >= cols_eff);
    last_row = (row_plus >= rows_eff);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_plus[RowW-1:0];
      end else begin
        col_nxt = col_plus[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col            = col_r;
  assign tag.last_col   = last_col;
  assign tag.row_number = row_r;
  assign tag.last_row   = last_row;

endmodule

/* sv/mvm_mac.sv */
`timescale 1ns / 1ps

module mvm_mac #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  mvm_pkg::tag_t                   start_tag,
  input  logic signed [ELEM_WIDTH-1:0]    start_val,
  input  logic signed [ELEM_WIDTH-1:0]    vec_data,
  output logic                            ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [mvm_pkg::ACC_W-1:0] out_row_sum,
  output logic [mvm_pkg::ROW_W-1:0]       out_row_number,
  output logic                            out_last_row
);

  localparam int AccW  = mvm_pkg::ACC_W;
  localparam int ProdW = 2 * ELEM_WIDTH;

  // stage 1: element waits for the vector read
  logic                         s1_v_r, s1_v_nxt;
  mvm_pkg::tag_t                s1_tag_r;
  logic signed [ELEM_WIDTH-1:0] s1_val_r;

  // stage 2: registered product
  logic                         s2_v_r, s2_v_nxt;
  mvm_pkg::tag_t                s2_tag_r;
  logic signed [ProdW-1:0]      s2_prod_r;

  logic signed [AccW-1:0]       acc_r, acc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [AccW-1:0]       out_sum_r;
  logic [mvm_pkg::ROW_W-1:0]    out_row_r;
  logic                         out_last_r;

  logic                         out_free;
  logic                         s2_adv;
  logic                         s2_take;
  logic                         s1_adv;
  logic signed [AccW-1:0]       prod_ext;
  logic signed [AccW-1:0]       sum;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    s2_adv   = s2_v_r && (!s2_tag_r.last_col || out_free);
    s2_take  = !s2_v_r || s2_adv;
    s1_adv   = s1_v_r && s2_take;
    ready    = !s1_v_r || s2_take;
    prod_ext = AccW'(s2_prod_r);
    sum      = acc_r + prod_ext;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (start) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end

    s2_v_nxt = s2_v_r;
    if (s1_adv) begin
      s2_v_nxt = 1'b1;
    end else if (s2_adv) begin
      s2_v_nxt = 1'b0;
    end

    acc_nxt = acc_r;
    if (s2_adv) begin
      acc_nxt = s2_tag_r.last_col ? '0 : sum;
    end

    out_valid_nxt = out_valid_r;
    if (s2_adv && s2_tag_r.last_col) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_tag_r <= start_tag;
      s1_val_r <= start_val;
    end
    if (s1_adv) begin
      s2_tag_r  <= s1_tag_r;
      s2_prod_r <= s1_val_r * vec_data;
    end
    if (s2_adv && s2_tag_r.last_col) begin
      out_sum_r  <= sum;
      out_row_r  <= s2_tag_r.row_number;
      out_last_r <= s2_tag_r.last_row;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_sum    = out_sum_r;
  assign out_row_number = out_row_r;
  assign out_last_row   = out_last_r;

endmodule

/* sv/matrix_vector_multiply.sv */
`timescale 1ns / 1ps

// Streaming dense matrix-vector multiply. Load the vector first with kind 0
// requests (one element each, by index), then stream the matrix row-major
// with kind 1 requests; each row of num_cols elements yields one result with
// the 40-bit row sum, the row number and a last-row flag. One request is
// taken every cycle unless in_ready drops, loads and matrix elements alike;
// a row result passes from the element register beside the vector RAM read
// to the product register and then to the accumulate stage that loads the
// result register. A stalled result holds back the pipeline only once it
// would be overwritten.
// The vector RAM has no reset; reading an entry that was never loaded gives
// an unspecified sum. Write configuration only while the block is idle.
module matrix_vector_multiply #(
  parameter int MAX_COLS   = 256,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic [mvm_pkg::IDX_W-1:0]             in_vector_index,
  input  logic signed [ELEM_WIDTH-1:0]          in_element_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mvm_pkg::ACC_W-1:0]      out_row_sum,
  output logic [mvm_pkg::ROW_W-1:0]             out_row_number,
  output logic                                  out_last_row,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int AddrW = $clog2(MAX_COLS);
  localparam int IdxCmpW = (mvm_pkg::IDX_W > AddrW ? mvm_pkg::IDX_W : AddrW) + 1;

  logic [mvm_pkg::COLS_REG_W-1:0] num_cols_r, num_cols_nxt;
  logic [mvm_pkg::ROWS_REG_W-1:0] num_rows_r, num_rows_nxt;

  logic                  accept;
  logic                  mat_acc;
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [AddrW-1:0]      rd_addr;
  logic [ELEM_WIDTH-1:0] ram_rdata;
  logic                  mac_ready;
  mvm_pkg::tag_t         seq_tag;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_cols_nxt = num_cols_r;
    num_rows_nxt = num_rows_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mvm_pkg::REG_NUM_COLS: num_cols_nxt = cfg_data[mvm_pkg::COLS_REG_W-1:0];
        mvm_pkg::REG_NUM_ROWS: num_rows_nxt = cfg_data[mvm_pkg::ROWS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= mvm_pkg::COLS_RESET;
      num_rows_r <= mvm_pkg::ROWS_RESET;
    end else begin
      num_cols_r <= num_cols_nxt;
      num_rows_r <= num_rows_nxt;
    end
  end

  assign in_ready = mac_ready;
  assign accept   = in_valid && in_ready;
  assign mat_acc  = accept && (in_kind == mvm_pkg::KIND_MATRIX);

  // drop loads that fall outside the store
  assign ram_we    = accept && (in_kind == mvm_pkg::KIND_VECTOR) &&
                     (IdxCmpW'(in_vector_index) < IdxCmpW'(MAX_COLS));
  assign ram_waddr = AddrW'(in_vector_index);

  mvm_seq #(
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (mat_acc),
    .num_cols (num_cols_r),
    .num_rows (num_rows_r),
    .col      (rd_addr),
    .tag      (seq_tag)
  );

  // at most one request per cycle, so a load and a read never meet in one cycle and
  // a read always sees every earlier load
  mvm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAX_COLS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_element_value),
    .re    (mat_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  mvm_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (mat_acc),
    .start_tag      (seq_tag),
    .start_val      (in_element_value),
    .vec_data       (ram_rdata),
    .ready          (mac_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_sum    (out_row_sum),
    .out_row_number (out_row_number),
    .out_last_row   (out_last_row)
  );

`ifndef SYNTH
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && mat_acc))
    else $error("vector load and matrix read in the same cycle");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (mat_acc && seq_tag.last_col) |=> (rd_addr == '0))
    else $error("column counter did not wrap at row end");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (mat_acc && seq_tag.last_col && seq_tag.last_row) |=> (seq_tag.row_number == '0))
    else $error("row counter did not wrap at matrix end");
`endif

endmodule

/* sim/mvm_row_checker.sv */
`timescale 1ns / 1ps

module mvm_row_checker #(
  parameter int MAX_COLS   = 256,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_kind,
  input  logic [mvm_pkg::IDX_W-1:0]         in_vector_index,
  input  logic signed [ELEM_WIDTH-1:0]      in_element_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [mvm_pkg::ACC_W-1:0]  out_row_sum,
  input  logic [mvm_pkg::ROW_W-1:0]         out_row_number,
  input  logic                              out_last_row,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                fail_count,
  output int                                pending
);

  typedef struct {
    logic signed [mvm_pkg::ACC_W-1:0] sum;
    logic [mvm_pkg::ROW_W-1:0]        row;
    logic                             last;
  } row_result_t;

  logic signed [ELEM_WIDTH-1:0]   vec_mem [0:MAX_COLS-1];
  logic [mvm_pkg::ACC_W-1:0]      acc;
  int unsigned                    col_cnt;
  int unsigned                    row_cnt;
  logic [mvm_pkg::COLS_REG_W-1:0] cols_reg;
  logic [mvm_pkg::ROWS_REG_W-1:0] rows_reg;
  row_result_t                    row_sums_due [$];

  always @(posedge clk) begin
    row_result_t                      got;
    row_result_t                      want;
    int unsigned                      cols_eff;
    int unsigned                      rows_eff;
    int unsigned                      col;
    logic signed [mvm_pkg::ACC_W-1:0] prod;
    if (!rst_n) begin
      acc        = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      cols_reg   = mvm_pkg::COLS_RESET;
      rows_reg   = mvm_pkg::ROWS_RESET;
      fail_count = 0;
      for (int i = 0; i < MAX_COLS; i++) vec_mem[i] = '0;
      row_sums_due.delete();
    end else begin
      // compare first: a request taken at this edge cannot finish at it
      if (out_valid && out_ready) begin
        got.sum  = out_row_sum;
        got.row  = out_row_number;
        got.last = out_last_row;
        if (row_sums_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected row result: sum %0d row %0d last %0b",
                     got.sum, got.row, got.last);
        end else begin
          want = row_sums_due.pop_front();
          if (got.sum !== want.sum || got.row !== want.row || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("row result mismatch: expected sum %0d row %0d last %0b,",
                       want.sum, want.row, want.last,
                       " got sum %0d row %0d last %0b",
                       got.sum, got.row, got.last);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mvm_pkg::REG_NUM_COLS)
          cols_reg = cfg_data[mvm_pkg::COLS_REG_W-1:0];
        else if (cfg_index == mvm_pkg::REG_NUM_ROWS)
          rows_reg = cfg_data[mvm_pkg::ROWS_REG_W-1:0];
      end

      if (in_valid && in_ready) begin
        if (in_kind == mvm_pkg::KIND_VECTOR) begin
          if (in_vector_index < MAX_COLS)
            vec_mem[in_vector_index] = in_element_value;
        end else begin
          cols_eff = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
          rows_eff = (rows_reg == 0) ? 1 : rows_reg;
          col      = (col_cnt < MAX_COLS) ? col_cnt : MAX_COLS - 1;
          prod     = in_element_value * vec_mem[col];
          acc      = acc + prod;
          if (col_cnt + 1 < cols_eff) begin
            col_cnt++;
          end else begin
            want.sum  = acc;
            want.row  = row_cnt[mvm_pkg::ROW_W-1:0];
            want.last = (row_cnt + 1 >= rows_eff);
            row_sums_due.push_back(want);
            acc     = '0;
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= rows_eff) ? 0 : row_cnt + 1;
          end
        end
      end
    end
    pending = row_sums_due.size();
  end

endmodule

/* sim/tb_matrix_vector_multiply.sv */
`timescale 1ns / 1ps

module tb_matrix_vector_multiply;

  localparam int MAX_COLS   = 256;
  localparam int ELEM_WIDTH = 16;
  localparam int ITEM_GOAL  = 1150;
  localparam int HOLD_CYCLES = 400;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic                               in_kind;
  logic [mvm_pkg::IDX_W-1:0]          in_vector_index;
  logic signed [ELEM_WIDTH-1:0]       in_element_value;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [mvm_pkg::ACC_W-1:0]   out_row_sum;
  logic [mvm_pkg::ROW_W-1:0]          out_row_number;
  logic                               out_last_row;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [mvm_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [mvm_pkg::CFG_DATA_W-1:0]     cfg_data;
  int                                 fail_count;
  int                                 pending;

  // stimulus-side bookkeeping so that no unloaded vector entry is ever read
  bit                             loaded [0:MAX_COLS-1];
  logic [mvm_pkg::COLS_REG_W-1:0] col_limit;
  int unsigned                    col_pos;
  int                             items_sent;
  bit                             fast_mode;
  bit                             stall_request;
  bit                             pressure_done;

  matrix_vector_multiply #(
    .MAX_COLS  (MAX_COLS),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_vector_index (in_vector_index),
    .in_element_value(in_element_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_sum     (out_row_sum),
    .out_row_number  (out_row_number),
    .out_last_row    (out_last_row),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  mvm_row_checker #(
    .MAX_COLS  (MAX_COLS),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_vector_index (in_vector_index),
    .in_element_value(in_element_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_sum     (out_row_sum),
    .out_row_number  (out_row_number),
    .out_last_row    (out_last_row),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned active_cols(input logic [mvm_pkg::COLS_REG_W-1:0] r);
    return (r == 0) ? 1 : (r > MAX_COLS) ? MAX_COLS : r;
  endfunction

  function automatic logic signed [ELEM_WIDTH-1:0] pick_element();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(ELEM_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  // present one request after a random gap (none in fast mode) and hold it until taken
  task automatic send_request(input logic kind, input logic [mvm_pkg::IDX_W-1:0] idx,
                              input logic signed [ELEM_WIDTH-1:0] value);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_kind          = kind;
    in_vector_index  = idx;
    in_element_value = value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_load(input logic [mvm_pkg::IDX_W-1:0] idx,
                           input logic signed [ELEM_WIDTH-1:0] value);
    send_request(mvm_pkg::KIND_VECTOR, idx, value);
    loaded[idx] = 1'b1;
  endtask

  task automatic send_matrix(input logic signed [ELEM_WIDTH-1:0] value);
    if (!loaded[col_pos[mvm_pkg::IDX_W-1:0]])
      send_load(col_pos[mvm_pkg::IDX_W-1:0], pick_element());
    send_request(mvm_pkg::KIND_MATRIX, (mvm_pkg::IDX_W)'($urandom), value);
    if (col_pos + 1 < active_cols(col_limit))
      col_pos++;
    else
      col_pos = 0;
  endtask

  // drain: drop valid, wait for every row result, then let loads settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mvm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == mvm_pkg::REG_NUM_COLS)
      col_limit = data[mvm_pkg::COLS_REG_W-1:0];
  endtask

  task automatic set_shape(input logic [mvm_pkg::CFG_DATA_W-1:0] cols,
                           input logic [mvm_pkg::CFG_DATA_W-1:0] rows);
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(mvm_pkg::REG_NUM_COLS, cols);
      write_reg(mvm_pkg::REG_NUM_ROWS, rows);
    end else begin
      write_reg(mvm_pkg::REG_NUM_ROWS, rows);
      write_reg(mvm_pkg::REG_NUM_COLS, cols);
    end
  endtask

  // receiver: random hold-off per result (none in fast mode), plus one long hold on request
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready     = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = fast_mode ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [mvm_pkg::CFG_DATA_W-1:0] cols;
    logic [mvm_pkg::CFG_DATA_W-1:0] rows;
    int                             n;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = mvm_pkg::KIND_VECTOR;
    in_vector_index  = '0;
    in_element_value = '0;
    cfg_valid        = 1'b0;
    cfg_index        = mvm_pkg::REG_NUM_COLS;
    cfg_data         = '0;
    col_limit        = mvm_pkg::COLS_RESET;
    col_pos          = 0;
    items_sent       = 0;
    fast_mode        = 1'b0;
    stall_request    = 1'b0;
    pressure_done    = 1'b0;
    for (int i = 0; i < MAX_COLS; i++) loaded[i] = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // extreme products, two rows per matrix
    set_shape(16'd3, 16'd2);
    send_load(8'd0, 16'sh8000);
    send_load(8'd1, 16'sh7FFF);
    send_load(8'd2, 16'shFFFF);
    send_matrix(16'sh8000);
    send_matrix(16'sh8000);
    send_matrix(16'sh8000);
    send_matrix(16'sh7FFF);
    send_matrix(16'sh8000);
    send_matrix(16'sh0000);

    // vector load in the middle of a row
    send_matrix(16'sd5);
    send_load(8'd1, 16'sd7);
    send_matrix(16'sd1);
    send_matrix(16'sd2);

    // shrink the row length while a row is open
    send_matrix(16'sd1);
    wait_idle();
    write_reg(mvm_pkg::REG_NUM_COLS, 16'd1);
    send_matrix(-16'sd3);

    // zero columns and zero rows, upper data bits set
    set_shape(16'hFE00, 16'h0000);
    send_matrix(16'sh7FFF);
    send_matrix(16'sh8000);
    send_load(8'd255, 16'sd12345);

    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 19))
        0:       cols = '0;
        1:       cols = (mvm_pkg::CFG_DATA_W)'(MAX_COLS);
        2:       cols = (mvm_pkg::CFG_DATA_W)'($urandom_range(MAX_COLS + 1, 511));
        3, 4, 5: cols = (mvm_pkg::CFG_DATA_W)'($urandom_range(9, 40));
        default: cols = (mvm_pkg::CFG_DATA_W)'($urandom_range(1, 8));
      endcase
      cols[mvm_pkg::CFG_DATA_W-1:mvm_pkg::COLS_REG_W] =
        (mvm_pkg::CFG_DATA_W - mvm_pkg::COLS_REG_W)'($urandom);
      case ($urandom_range(0, 9))
        0:       rows = '0;
        1:       rows = 16'hFFFF;
        2:       rows = (mvm_pkg::CFG_DATA_W)'($urandom);
        default: rows = (mvm_pkg::CFG_DATA_W)'($urandom_range(1, 5));
      endcase
      set_shape(cols, rows);
      fast_mode = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 70);
      repeat (n) begin
        if ($urandom_range(0, 6) == 0)
          send_load((mvm_pkg::IDX_W)'($urandom_range(0, MAX_COLS - 1)), pick_element());
        else
          send_matrix(pick_element());
      end

      // one-column matrix stream against a stalled receiver to back up the pipe
      if (!pressure_done && items_sent > 400) begin
        pressure_done = 1'b1;
        set_shape(16'd1, 16'd3);
        fast_mode     = 1'b1;
        stall_request = 1'b1;
        repeat (80) send_matrix(pick_element());
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
sv/mvm_pkg.sv
sv/mvm_ram.sv
sv/mvm_seq.sv
sv/mvm_mac.sv
sv/matrix_vector_multiply.sv
sim/mvm_row_checker.sv
sim/tb_matrix_vector_multiply.sv
